@@ rtl/icpr_pkg.sv @@
// ----------------------------------------------------------------------------
// icpr_pkg
// Shared types and constants of the ICMP probe reply classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package icpr_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_ID  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SEQ = 8'd1;

  localparam int ICMP_STRUCT_BYTES = 28;
  localparam int IP_STRUCT_BYTES   = 20;
  localparam int ICMP_HDR_OFFSET   = 8;
  localparam int ICMP_ID_OFFSET    = 4;
  localparam int ICMP_SEQ_OFFSET   = 6;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  typedef enum logic [1:0] {
    VERDICT_TARGET    = 2'd0,
    VERDICT_HOP       = 2'd1,
    VERDICT_NOT_OURS  = 2'd2,
    VERDICT_TOO_SHORT = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [5:0]  outer_header_bytes;
    logic [5:0]  inner_header_bytes;
    logic [7:0]  message_type;
    logic [15:0] outer_ident;
    logic [15:0] outer_sequence;
    logic [15:0] inner_ident;
    logic [15:0] inner_sequence;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/icpr_if.sv @@
// ----------------------------------------------------------------------------
// icpr_if
// Channel interfaces: datagram byte stream, verdict stream, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface icpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icpr_out_if #(parameter int LEN_W = 11);
  logic             valid;
  logic             ready;
  logic [1:0]       verdict;
  logic [LEN_W-1:0] received_length;

  modport source (output valid, output verdict, output received_length, input ready);
  modport sink   (input valid, input verdict, input received_length, output ready);
endinterface

interface icpr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [icpr_pkg::CFG_INDEX_W-1:0] index;
  logic [icpr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/icpr_capture.sv @@
// ----------------------------------------------------------------------------
// icpr_capture
// Input register and header field capture; hands a frame snapshot to the
// judge stage on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module icpr_capture #(
  parameter int  BUFFER_BYTES = 1024,
  localparam int PW           = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  icpr_in_if.sink                rx,
  output icpr_pkg::frame_t       snap,
  output logic [PW-1:0]          snap_count,
  output logic                   snap_valid,
  input  wire logic              snap_ready
);

  localparam int CW = ((PW > 8) ? PW : 8) + 1;

  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_last;
  logic             take;

  logic [PW-1:0]    byte_position;
  logic [PW-1:0]    byte_position_next;
  icpr_pkg::frame_t frame;
  icpr_pkg::frame_t frame_next;

  logic [5:0]       hl_in;
  logic [5:0]       ohl_eff;
  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    ohl_w;
  logic [CW-1:0]    ipos;
  logic [CW-1:0]    qpos;

  assign take     = hold_valid && (!hold_last || !snap_valid || snap_ready);
  assign rx.ready = !hold_valid || take;

  always_comb begin
    frame_next         = frame;
    byte_position_next = byte_position;
    hl_in              = {hold_byte[3:0], 2'b00};
    ohl_eff            = (byte_position == '0) ? hl_in : frame.outer_header_bytes;
    pos_w              = CW'(byte_position);
    ohl_w              = CW'(ohl_eff);
    ipos               = ohl_w + CW'(icpr_pkg::ICMP_HDR_OFFSET);
    qpos               = ipos + CW'(frame.inner_header_bytes);
    if (byte_position < PW'(BUFFER_BYTES)) begin
      byte_position_next = byte_position + PW'(1);
      frame_next.outer_header_bytes = ohl_eff;
      if (pos_w == ohl_w)
        frame_next.message_type = hold_byte;
      if (pos_w == ohl_w + CW'(icpr_pkg::ICMP_ID_OFFSET))
        frame_next.outer_ident[15:8] = hold_byte;
      if (pos_w == ohl_w + CW'(icpr_pkg::ICMP_ID_OFFSET + 1))
        frame_next.outer_ident[7:0] = hold_byte;
      if (pos_w == ohl_w + CW'(icpr_pkg::ICMP_SEQ_OFFSET))
        frame_next.outer_sequence[15:8] = hold_byte;
      if (pos_w == ohl_w + CW'(icpr_pkg::ICMP_SEQ_OFFSET + 1))
        frame_next.outer_sequence[7:0] = hold_byte;
      if (pos_w == ipos)
        frame_next.inner_header_bytes = hl_in;
      if (pos_w > ipos) begin
        if (pos_w == qpos + CW'(icpr_pkg::ICMP_ID_OFFSET))
          frame_next.inner_ident[15:8] = hold_byte;
        if (pos_w == qpos + CW'(icpr_pkg::ICMP_ID_OFFSET + 1))
          frame_next.inner_ident[7:0] = hold_byte;
        if (pos_w == qpos + CW'(icpr_pkg::ICMP_SEQ_OFFSET))
          frame_next.inner_sequence[15:8] = hold_byte;
        if (pos_w == qpos + CW'(icpr_pkg::ICMP_SEQ_OFFSET + 1))
          frame_next.inner_sequence[7:0] = hold_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      snap_valid    <= 1'b0;
      byte_position <= '0;
      frame         <= '0;
    end else begin
      if (rx.ready)
        hold_valid <= rx.valid;
      snap_valid <= (take && hold_last) || (snap_valid && !snap_ready);
      if (take) begin
        if (hold_last) begin
          byte_position <= '0;
          frame         <= '0;
        end else begin
          byte_position <= byte_position_next;
          frame         <= frame_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      hold_byte <= rx.data_byte;
      hold_last <= rx.last_byte;
    end
    if (take && hold_last) begin
      snap       <= frame_next;
      snap_count <= byte_position_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/icpr_judge.sv @@
// ----------------------------------------------------------------------------
// icpr_judge
// Length and identity checks on a finished frame; result register.
// ----------------------------------------------------------------------------
`default_nettype none

module icpr_judge #(
  parameter int  BUFFER_BYTES = 1024,
  localparam int PW           = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire icpr_pkg::frame_t          snap,
  input  wire logic [PW-1:0]             snap_count,
  input  wire logic                      snap_valid,
  output logic                           snap_ready,
  input  wire logic [15:0]               expected_id,
  input  wire logic [15:0]               expected_seq,
  icpr_out_if.source                     result
);

  localparam int CW = ((PW > 8) ? PW : 8) + 1;

  logic               out_free;
  logic [CW-1:0]      n;
  logic [CW-1:0]      ohl;
  logic [CW-1:0]      ihl;
  logic               outer_match;
  logic               inner_match;
  icpr_pkg::verdict_t verdict_next;

  assign out_free   = !result.valid || result.ready;
  assign snap_ready = out_free;

  assign n           = CW'(snap_count);
  assign ohl         = CW'(snap.outer_header_bytes);
  assign ihl         = CW'(snap.inner_header_bytes);
  assign outer_match = (snap.outer_ident == expected_id) &&
                       (snap.outer_sequence == expected_seq);
  assign inner_match = (snap.inner_ident == expected_id) &&
                       (snap.inner_sequence == expected_seq);

  always_comb begin
    verdict_next = icpr_pkg::VERDICT_NOT_OURS;
    if (n < ohl + CW'(icpr_pkg::ICMP_STRUCT_BYTES)) begin
      verdict_next = icpr_pkg::VERDICT_TOO_SHORT;
    end else if (snap.message_type == icpr_pkg::TYPE_ECHO_REPLY && outer_match) begin
      verdict_next = icpr_pkg::VERDICT_TARGET;
    end else if (snap.message_type == icpr_pkg::TYPE_TIME_EXCEEDED) begin
      if (n < ohl + CW'(icpr_pkg::ICMP_HDR_OFFSET + icpr_pkg::IP_STRUCT_BYTES +
                        icpr_pkg::ICMP_STRUCT_BYTES))
        verdict_next = icpr_pkg::VERDICT_HOP;
      else if (n < ohl + ihl + CW'(icpr_pkg::ICMP_HDR_OFFSET + icpr_pkg::ICMP_STRUCT_BYTES))
        verdict_next = icpr_pkg::VERDICT_HOP;
      else if (inner_match)
        verdict_next = icpr_pkg::VERDICT_HOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      result.verdict         <= verdict_next;
      result.received_length <= snap_count;
    end
  end

endmodule

`default_nettype wire

@@ rtl/icmp_probe_reply_classifier.sv @@
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Classifies a received IPv4 datagram as a reply to our probe.
//
// rx carries the datagram one byte per transaction, last_byte set on the
// final byte. cfg writes expected_id (index 0) and expected_seq (index 1);
// both read zero after reset. result carries one transaction per datagram:
// verdict (0 target reached, 1 intermediate hop, 2 not ours, 3 too short)
// and received_length, the byte count saturated at BUFFER_BYTES.
// Throughput is one byte per cycle while rx.ready is high. A byte is held
// in an input register, its header fields are then captured, and the
// verdict of a final byte is then loaded into the result register, from
// which it is offered on result.
// The result register frees up whenever it is taken; while result is
// stalled, non-final bytes keep flowing, and rx.ready drops only once a
// second finished datagram is waiting behind the held verdict.
// Reset empties the pipeline and clears the frame state and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_probe_reply_classifier #(
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst,
  icpr_cfg_if.sink    cfg,
  icpr_in_if.sink     rx,
  icpr_out_if.source  result
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);

  logic [15:0]      expected_id;
  logic [15:0]      expected_seq;
  icpr_pkg::frame_t snap;
  logic [PW-1:0]    snap_count;
  logic             snap_valid;
  logic             snap_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id  <= '0;
      expected_seq <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        icpr_pkg::REG_EXPECTED_ID:  expected_id  <= cfg.data;
        icpr_pkg::REG_EXPECTED_SEQ: expected_seq <= cfg.data;
        default: ;
      endcase
    end
  end

  icpr_capture #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .snap       (snap),
    .snap_count (snap_count),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  icpr_judge #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_judge (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .snap_count   (snap_count),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .expected_id  (expected_id),
    .expected_seq (expected_seq),
    .result       (result)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_length_saturates: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.received_length <= PW'(BUFFER_BYTES))
    else $error("received_length beyond buffer size");

  a_short_verdict: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.verdict != icpr_pkg::VERDICT_TOO_SHORT |->
      result.received_length >= PW'(icpr_pkg::ICMP_STRUCT_BYTES))
    else $error("verdict given on a frame shorter than an ICMP message");

endmodule

`default_nettype wire
